/* rtl/bpa_pkg.sv */
// Buddy page allocator package: field widths, codes, controller states,
// datapath commands and status flags. No dependencies.
package bpa_pkg;

  localparam int MODE_W      = 2;
  localparam int PAGE_W      = 12;
  localparam int COUNT_W     = 13;
  localparam int ORDER_W     = 5;
  localparam int STATUS_W    = 2;

  localparam int NUM_PAGES_DEF = 4096;
  localparam int MAX_ORDER_DEF = 10;

  typedef enum logic [MODE_W-1:0] {
    MODE_COUNT = 2'd0,
    MODE_ORDER = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_BAD   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_OOM     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_TAKE,
    S_SPLIT,
    S_FR_STEP,
    S_PB_START,
    S_PB_MARK,
    S_PB_BUD,
    S_PB_CLR2,
    S_RESP_OK,
    S_RESP_ERR,
    S_RESP_ALLOC
  } state_t;

  typedef enum logic [1:0] {
    PH_SPLIT,
    PH_FREE,
    PH_TAIL
  } phase_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_INIT,
    OP_CUR_INC,
    OP_SCAN_RD,
    OP_SCAN_NEXT,
    OP_TAKE,
    OP_SPLIT,
    OP_TAIL_INIT,
    OP_FR_STEP,
    OP_PB_RD,
    OP_PB_MARK,
    OP_PB_CLR1,
    OP_PB_CLR2,
    OP_RES
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t st;
    logic    with_page;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic req_bad;
    logic req_nop;
    logic req_free;
    logic cur_over;
    logic cnt_zero;
    logic scan_end;
    logic rd_set;
    logic split_more;
    logic tail;
    logic fr_done;
    logic pb_oob;
    logic pb_top;
    logic out_free;
  } sts_t;

endpackage

/* rtl/bpa_if.sv */
// Request and response channel interfaces for the buddy page allocator.
// Depends on bpa_pkg for field widths.
interface bpa_req_if;
  logic                           valid;
  logic                           ready;
  logic [bpa_pkg::MODE_W-1:0]     mode;
  logic [bpa_pkg::PAGE_W-1:0]     page_number;
  logic [bpa_pkg::COUNT_W-1:0]    count;
  logic [bpa_pkg::ORDER_W-1:0]    order;
  modport source (output valid, mode, page_number, count, order, input ready);
  modport sink (input valid, mode, page_number, count, order, output ready);
endinterface

interface bpa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bpa_pkg::STATUS_W-1:0]   status;
  logic [bpa_pkg::PAGE_W-1:0]     page_number_res;
  modport source (output valid, status, page_number_res, input ready);
  modport sink (input valid, status, page_number_res, output ready);
endinterface

/* rtl/bpa_ctrl.sv */
// Buddy page allocator controller: sequences search, split, free and merge.
// Depends on bpa_pkg; drives commands into bpa_dp and reads its status.
module bpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bpa_pkg::sts_t sts,
  output bpa_pkg::cmd_t cmd
);

  bpa_pkg::state_t state, state_next;
  bpa_pkg::phase_t phase, phase_next;
  bpa_pkg::state_t pb_ret;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpa_pkg::S_CLEAR;
      phase <= bpa_pkg::PH_FREE;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    pb_ret = (phase == bpa_pkg::PH_SPLIT) ? bpa_pkg::S_SPLIT : bpa_pkg::S_FR_STEP;
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state)
      bpa_pkg::S_CLEAR:    if (sts.clr_done) state_next = bpa_pkg::S_IDLE;
      bpa_pkg::S_IDLE:     if (in_valid) state_next = bpa_pkg::S_DECODE;
      bpa_pkg::S_DECODE: begin
        if (sts.req_bad) begin
          state_next = bpa_pkg::S_RESP_ERR;
        end else if (sts.req_nop) begin
          state_next = bpa_pkg::S_RESP_OK;
        end else if (sts.req_free) begin
          state_next = bpa_pkg::S_FR_STEP;
          phase_next = bpa_pkg::PH_FREE;
        end else begin
          state_next = bpa_pkg::S_FIND;
        end
      end
      bpa_pkg::S_FIND: begin
        if (sts.cur_over) state_next = bpa_pkg::S_RESP_ERR;
        else if (!sts.cnt_zero) state_next = bpa_pkg::S_SCAN_RD;
      end
      bpa_pkg::S_SCAN_RD: begin
        state_next = sts.scan_end ? bpa_pkg::S_RESP_ERR : bpa_pkg::S_SCAN_CHK;
      end
      bpa_pkg::S_SCAN_CHK: begin
        state_next = sts.rd_set ? bpa_pkg::S_TAKE : bpa_pkg::S_SCAN_RD;
      end
      bpa_pkg::S_TAKE:     state_next = bpa_pkg::S_SPLIT;
      bpa_pkg::S_SPLIT: begin
        if (sts.split_more) begin
          state_next = bpa_pkg::S_PB_START;
          phase_next = bpa_pkg::PH_SPLIT;
        end else if (sts.tail) begin
          state_next = bpa_pkg::S_FR_STEP;
          phase_next = bpa_pkg::PH_TAIL;
        end else begin
          state_next = bpa_pkg::S_RESP_ALLOC;
        end
      end
      bpa_pkg::S_FR_STEP: begin
        if (!sts.fr_done) state_next = bpa_pkg::S_PB_START;
        else if (phase == bpa_pkg::PH_TAIL) state_next = bpa_pkg::S_RESP_ALLOC;
        else state_next = bpa_pkg::S_RESP_OK;
      end
      bpa_pkg::S_PB_START: state_next = sts.pb_oob ? pb_ret : bpa_pkg::S_PB_MARK;
      bpa_pkg::S_PB_MARK:  state_next = sts.pb_top ? pb_ret : bpa_pkg::S_PB_BUD;
      bpa_pkg::S_PB_BUD:   state_next = sts.rd_set ? bpa_pkg::S_PB_CLR2 : pb_ret;
      bpa_pkg::S_PB_CLR2:  state_next = bpa_pkg::S_PB_START;
      bpa_pkg::S_RESP_OK,
      bpa_pkg::S_RESP_ERR,
      bpa_pkg::S_RESP_ALLOC: if (sts.out_free) state_next = bpa_pkg::S_IDLE;
      default:             state_next = bpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.op        = bpa_pkg::OP_NONE;
    cmd.st        = bpa_pkg::ST_OK;
    cmd.with_page = 1'b0;
    unique case (state)
      bpa_pkg::S_CLEAR:    cmd.op = bpa_pkg::OP_CLEAR;
      bpa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = bpa_pkg::OP_LOAD;
      end
      bpa_pkg::S_DECODE:   cmd.op = bpa_pkg::OP_INIT;
      bpa_pkg::S_FIND: begin
        if (!sts.cur_over && sts.cnt_zero) cmd.op = bpa_pkg::OP_CUR_INC;
      end
      bpa_pkg::S_SCAN_RD:  if (!sts.scan_end) cmd.op = bpa_pkg::OP_SCAN_RD;
      bpa_pkg::S_SCAN_CHK: if (!sts.rd_set) cmd.op = bpa_pkg::OP_SCAN_NEXT;
      bpa_pkg::S_TAKE:     cmd.op = bpa_pkg::OP_TAKE;
      bpa_pkg::S_SPLIT: begin
        if (sts.split_more) cmd.op = bpa_pkg::OP_SPLIT;
        else if (sts.tail) cmd.op = bpa_pkg::OP_TAIL_INIT;
      end
      bpa_pkg::S_FR_STEP:  if (!sts.fr_done) cmd.op = bpa_pkg::OP_FR_STEP;
      bpa_pkg::S_PB_START: if (!sts.pb_oob) cmd.op = bpa_pkg::OP_PB_RD;
      bpa_pkg::S_PB_MARK:  cmd.op = bpa_pkg::OP_PB_MARK;
      bpa_pkg::S_PB_BUD:   if (sts.rd_set) cmd.op = bpa_pkg::OP_PB_CLR1;
      bpa_pkg::S_PB_CLR2:  cmd.op = bpa_pkg::OP_PB_CLR2;
      bpa_pkg::S_RESP_OK: begin
        if (sts.out_free) cmd.op = bpa_pkg::OP_RES;
      end
      bpa_pkg::S_RESP_ERR: begin
        if (sts.out_free) cmd.op = bpa_pkg::OP_RES;
        cmd.st = sts.req_bad ? bpa_pkg::ST_INVALID : bpa_pkg::ST_OOM;
      end
      bpa_pkg::S_RESP_ALLOC: begin
        if (sts.out_free) cmd.op = bpa_pkg::OP_RES;
        cmd.with_page = 1'b1;
      end
      default:             cmd.op = bpa_pkg::OP_NONE;
    endcase
  end

endmodule

/* rtl/bpa_dp.sv */
// Buddy page allocator datapath: free-mark memory, per-order free counts,
// request and block registers, result register. Depends on bpa_pkg, bpa_if.
module bpa_dp #(
  parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF,
  parameter int MAX_ORDER = bpa_pkg::MAX_ORDER_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bpa_pkg::MODE_W-1:0]  in_mode,
  input  logic [bpa_pkg::PAGE_W-1:0]  in_page,
  input  logic [bpa_pkg::COUNT_W-1:0] in_count,
  input  logic [bpa_pkg::ORDER_W-1:0] in_order,
  input  bpa_pkg::cmd_t               cmd,
  output bpa_pkg::sts_t               sts,
  bpa_rsp_if.source                   rsp
);

  localparam int AW    = $clog2(NUM_PAGES) + 1;
  localparam int DEPTH = 2 * NUM_PAGES;
  localparam int OW    = $clog2(MAX_ORDER + 2);
  localparam int IW    = $clog2(MAX_ORDER + 1);

  logic                        mem [0:DEPTH-1];
  logic                        rdata;
  logic [AW-1:0]               counts [0:MAX_ORDER];

  bpa_pkg::mode_t              mode;
  logic [bpa_pkg::PAGE_W-1:0]  page;
  logic [bpa_pkg::COUNT_W-1:0] cnt;
  logic [bpa_pkg::ORDER_W-1:0] ord;

  logic [OW-1:0] cur, ro, po;
  logic [AW-1:0] idx_i, p, pp, fp, fn, clr;

  logic                        res_valid;
  bpa_pkg::status_t            res_status;
  logic [bpa_pkg::PAGE_W-1:0]  res_page;

  logic [AW-1:0]  idx, bud, scan_addr, idx_addr, bud_addr, raddr, waddr;
  logic           we, wdata;
  logic [OW-1:0]  caddr, fo, o_calc;
  logic [bpa_pkg::ORDER_W-1:0] o5;
  logic           overflow, run;

  function automatic logic [AW-1:0] base_of(input logic [OW-1:0] o);
    base_of = AW'(DEPTH - (DEPTH >> o));
  endfunction

  always_comb begin
    idx       = pp >> po;
    bud       = idx ^ AW'(1);
    scan_addr = base_of(cur) + idx_i;
    idx_addr  = base_of(po) + idx;
    bud_addr  = base_of(po) + bud;
    overflow  = 32'(15'(page) + 15'(cnt)) > NUM_PAGES;
  end

  always_comb begin
    o5 = '0;
    if (mode == bpa_pkg::MODE_COUNT) begin
      for (int k = 0; k < bpa_pkg::COUNT_W; k++) begin
        if ((14'(1) << k) < 14'(cnt)) o5 = bpa_pkg::ORDER_W'(k + 1);
      end
    end else begin
      o5 = ord;
    end
    o_calc = OW'(o5);
  end

  always_comb begin
    fo  = '0;
    run = 1'b1;
    for (int k = 0; k < MAX_ORDER; k++) begin
      if (run && (32'd2 << k) <= 32'(fn) && (32'(fp) & ((32'd2 << k) - 32'd1)) == 32'd0)
        fo = OW'(k + 1);
      else
        run = 1'b0;
    end
  end

  always_comb begin
    caddr = (cmd.op == bpa_pkg::OP_PB_MARK || cmd.op == bpa_pkg::OP_PB_CLR1) ? po : cur;
  end

  always_comb begin
    sts.clr_done   = 32'(clr) == DEPTH - 1;
    sts.req_bad    = 1'b0;
    sts.req_nop    = 1'b0;
    sts.req_free   = 1'b0;
    case (mode)
      bpa_pkg::MODE_COUNT: sts.req_bad = cnt == '0 || 32'(cnt) > (32'd1 << MAX_ORDER);
      bpa_pkg::MODE_ORDER: sts.req_bad = 32'(ord) > MAX_ORDER;
      bpa_pkg::MODE_FREE: begin
        sts.req_bad  = cnt != '0 && overflow;
        sts.req_nop  = cnt == '0 || (!overflow && page == '0);
        sts.req_free = cnt != '0 && !overflow && page != '0;
      end
      default:             sts.req_bad = 1'b1;
    endcase
    sts.cur_over   = 32'(cur) > MAX_ORDER;
    sts.cnt_zero   = counts[cur[IW-1:0]] == '0;
    sts.scan_end   = 32'(idx_i) >= (NUM_PAGES >> cur);
    sts.rd_set     = rdata;
    sts.split_more = cur > ro;
    sts.tail       = mode == bpa_pkg::MODE_COUNT && (32'd1 << ro) > 32'(cnt);
    sts.fr_done    = fn == '0;
    sts.pb_oob     = 32'(idx) >= (NUM_PAGES >> po);
    sts.pb_top     = 32'(po) >= MAX_ORDER || 32'(bud) >= (NUM_PAGES >> po);
    sts.out_free   = !res_valid || rsp.ready;
  end

  always_comb begin
    we    = 1'b0;
    wdata = 1'b0;
    waddr = idx_addr;
    raddr = scan_addr;
    unique case (cmd.op)
      bpa_pkg::OP_CLEAR: begin
        we    = 1'b1;
        waddr = clr;
      end
      bpa_pkg::OP_TAKE: begin
        we    = 1'b1;
        waddr = scan_addr;
      end
      bpa_pkg::OP_PB_RD:   raddr = idx_addr;
      bpa_pkg::OP_PB_MARK: begin
        we    = !rdata;
        wdata = 1'b1;
        raddr = bud_addr;
      end
      bpa_pkg::OP_PB_CLR1: we = 1'b1;
      bpa_pkg::OP_PB_CLR2: begin
        we    = 1'b1;
        waddr = bud_addr;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
      for (int k = 0; k <= MAX_ORDER; k++) counts[k] <= '0;
    end else begin
      if (cmd.op == bpa_pkg::OP_CLEAR) clr <= clr + AW'(1);
      case (cmd.op)
        bpa_pkg::OP_TAKE:    counts[caddr[IW-1:0]] <= counts[caddr[IW-1:0]] - AW'(1);
        bpa_pkg::OP_PB_MARK: begin
          if (!rdata) counts[caddr[IW-1:0]] <= counts[caddr[IW-1:0]] + AW'(1);
        end
        bpa_pkg::OP_PB_CLR1: counts[caddr[IW-1:0]] <= counts[caddr[IW-1:0]] - AW'(2);
        default:             ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      bpa_pkg::OP_LOAD: begin
        mode <= bpa_pkg::mode_t'(in_mode);
        page <= in_page;
        cnt  <= in_count;
        ord  <= in_order;
      end
      bpa_pkg::OP_INIT: begin
        cur   <= o_calc;
        ro    <= o_calc;
        idx_i <= '0;
        fp    <= AW'(page);
        fn    <= AW'(cnt);
      end
      bpa_pkg::OP_CUR_INC:   cur <= cur + OW'(1);
      bpa_pkg::OP_SCAN_NEXT: idx_i <= idx_i + AW'(1);
      bpa_pkg::OP_TAKE:      p <= idx_i << cur;
      bpa_pkg::OP_SPLIT: begin
        cur <= cur - OW'(1);
        po  <= cur - OW'(1);
        pp  <= p + (AW'(1) << (cur - OW'(1)));
      end
      bpa_pkg::OP_TAIL_INIT: begin
        fp <= p + AW'(cnt);
        fn <= (AW'(1) << ro) - AW'(cnt);
      end
      bpa_pkg::OP_FR_STEP: begin
        pp <= fp;
        po <= fo;
        fp <= fp + (AW'(1) << fo);
        fn <= fn - (AW'(1) << fo);
      end
      bpa_pkg::OP_PB_CLR2: begin
        pp <= (idx & ~AW'(1)) << po;
        po <= po + OW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.op == bpa_pkg::OP_RES) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == bpa_pkg::OP_RES) begin
      res_status <= cmd.st;
      res_page   <= cmd.with_page ? bpa_pkg::PAGE_W'(p) : '0;
    end
  end

  assign rsp.valid           = res_valid;
  assign rsp.status          = res_status;
  assign rsp.page_number_res = res_page;

endmodule

/* rtl/buddy_page_allocator.sv */
// Buddy page allocator top level: joins controller and datapath.
// Depends on bpa_pkg, bpa_if, bpa_ctrl, bpa_dp.
//
//   channel  dir  words
//   req      in   mode, page_number, count, order
//   rsp      out  status, page_number_res
//
// After reset a clearing pass wipes all 2*NUM_PAGES free-mark entries; req is
// not ready meanwhile. One request at a time: ready only when idle.
// Allocation: steps past each empty order, scans the found order with a read and
// a check per free mark (up to NUM_PAGES>>order marks), then splits and merges
// in the PB states. Free: a step per aligned block plus its merge steps.
// A held result in the rsp register stalls only the final step.
module buddy_page_allocator #(
  parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF,
  parameter int MAX_ORDER = bpa_pkg::MAX_ORDER_DEF
) (
  input logic        clk,
  input logic        rst,
  bpa_req_if.sink    req,
  bpa_rsp_if.source  rsp
);

  bpa_pkg::cmd_t cmd;
  bpa_pkg::sts_t sts;
  logic          in_ready;

  assign req.ready = in_ready;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpa_dp #(
    .NUM_PAGES (NUM_PAGES),
    .MAX_ORDER (MAX_ORDER)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_mode  (req.mode),
    .in_page  (req.page_number),
    .in_count (req.count),
    .in_order (req.order),
    .cmd      (cmd),
    .sts      (sts),
    .rsp      (rsp)
  );

endmodule

/* tb/testbench.sv */
// Testbench for buddy_page_allocator: directed table then random requests,
// each response checked against a local model of the free store.
// Depends on bpa_pkg, bpa_if and the buddy_page_allocator RTL.
module testbench;

  localparam int NPG = 4096;
  localparam int MAXO = 10;
  localparam int NRAND = 430;
  localparam int WDOG_LIMIT = 40000;

  typedef struct {
    logic [1:0]       mode;
    logic [11:0]      page;
    logic [12:0]      cnt;
    logic [4:0]       ord;
    bit               typed;
    bpa_pkg::status_t st;
    logic [11:0]      pg;
  } req_row_t;

  typedef struct {
    bpa_pkg::status_t st;
    logic [11:0]      pg;
  } rsp_word_t;

  typedef struct {
    int unsigned base;
    int unsigned size;
  } block_t;

  logic clk = 0;
  logic rst = 1;
  bpa_req_if req_ch();
  bpa_rsp_if rsp_ch();

  buddy_page_allocator u_top (.clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch));

  always #10 clk = ~clk;

  bit          free_bit[2*NPG];
  int unsigned free_num[MAXO+1];
  rsp_word_t   pending_rsp[$];
  block_t      held_blocks[$];
  int          errors = 0;
  int          n_sent = 0;
  bit          idle_on = 1;
  bit          sending = 1;
  int          quiet = 0;

  function automatic int unsigned order_base(int unsigned o);
    return 2*NPG - ((2*NPG) >> o);
  endfunction

  function automatic void mark_merge(int unsigned p, int unsigned o);
    int unsigned b, idx, bud;
    forever begin
      b = order_base(o);
      idx = p >> o;
      if (idx >= (NPG >> o)) return;
      if (!free_bit[b+idx]) begin
        free_bit[b+idx] = 1;
        free_num[o]++;
      end
      if (o >= MAXO) return;
      bud = idx ^ 1;
      if (bud >= (NPG >> o) || !free_bit[b+bud]) return;
      free_bit[b+idx] = 0;
      free_bit[b+bud] = 0;
      free_num[o] -= 2;
      p = (idx & ~1) << o;
      o++;
    end
  endfunction

  function automatic void release_pages(int unsigned p, int unsigned n);
    int unsigned o;
    while (n > 0) begin
      o = 0;
      while (o < MAXO && (2 << o) <= n && (p & ((2 << o) - 1)) == 0) o++;
      mark_merge(p, o);
      p += 1 << o;
      n -= 1 << o;
    end
  endfunction

  function automatic bpa_pkg::status_t take_block(int unsigned o, output int unsigned pg);
    int unsigned c, b, i;
    c = o;
    pg = 0;
    while (c <= MAXO && free_num[c] == 0) c++;
    if (c > MAXO) return bpa_pkg::ST_OOM;
    b = order_base(c);
    for (i = 0; i < (NPG >> c); i++) if (free_bit[b+i]) break;
    if (i >= (NPG >> c)) return bpa_pkg::ST_OOM;
    free_bit[b+i] = 0;
    free_num[c]--;
    pg = i << c;
    while (c > o) begin
      c--;
      mark_merge(pg + (1 << c), c);
    end
    return bpa_pkg::ST_OK;
  endfunction

  function automatic rsp_word_t allocate_or_free(req_row_t r);
    rsp_word_t w;
    int unsigned o, p;
    w.st = bpa_pkg::ST_OK;
    w.pg = 0;
    p = 0;
    case (r.mode)
      bpa_pkg::MODE_COUNT: begin
        if (r.cnt == 0 || r.cnt > (1 << MAXO)) w.st = bpa_pkg::ST_INVALID;
        else begin
          o = 0;
          while ((1 << o) < r.cnt) o++;
          w.st = take_block(o, p);
          if (w.st == bpa_pkg::ST_OK) begin
            if ((1 << o) > r.cnt) release_pages(p + r.cnt, (1 << o) - r.cnt);
            w.pg = 12'(p);
            held_blocks.push_back('{p, r.cnt});
          end
        end
      end
      bpa_pkg::MODE_ORDER: begin
        if (r.ord > MAXO) w.st = bpa_pkg::ST_INVALID;
        else begin
          w.st = take_block(r.ord, p);
          if (w.st == bpa_pkg::ST_OK) begin
            w.pg = 12'(p);
            held_blocks.push_back('{p, 1 << r.ord});
          end
        end
      end
      bpa_pkg::MODE_FREE: begin
        if (r.cnt == 0) w.st = bpa_pkg::ST_OK;
        else if (r.page + r.cnt > NPG) w.st = bpa_pkg::ST_INVALID;
        else if (r.page != 0) release_pages(r.page, r.cnt);
      end
      default: w.st = bpa_pkg::ST_INVALID;
    endcase
    return w;
  endfunction

  function automatic req_row_t row(logic [1:0] m, int pgn, int c, int o,
                                   bit t = 0, bpa_pkg::status_t s = bpa_pkg::ST_OK);
    req_row_t r;
    r.mode = m;
    r.page = 12'(pgn);
    r.cnt = 13'(c);
    r.ord = 5'(o);
    r.typed = t;
    r.st = s;
    r.pg = 0;
    return r;
  endfunction

  function automatic req_row_t random_request();
    req_row_t r;
    block_t blk;
    int k, sel;
    sel = $urandom_range(0, 99);
    r = row(bpa_pkg::MODE_BAD, 0, 0, 0);
    if (sel < 40 && held_blocks.size() > 0) begin
      k = $urandom_range(0, held_blocks.size() - 1);
      blk = held_blocks[k];
      if ($urandom_range(0, 9) != 0) held_blocks.delete(k);
      r.mode = bpa_pkg::MODE_FREE;
      r.page = 12'(blk.base);
      r.cnt = 13'(blk.size);
      if ($urandom_range(0, 5) == 0) begin
        r.page = 12'(blk.base + $urandom_range(0, blk.size - 1));
        r.cnt = 13'($urandom_range(1, blk.base + blk.size - r.page));
      end
    end else if (sel < 70) begin
      r.mode = bpa_pkg::MODE_COUNT;
      r.cnt = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(1, 1024))
                                          : 13'($urandom_range(1, 64));
    end else if (sel < 85) begin
      r.mode = bpa_pkg::MODE_ORDER;
      r.ord = 5'($urandom_range(0, MAXO));
    end else begin
      r.mode = 2'($urandom_range(0, 3));
      r.page = 12'($urandom);
      r.cnt = 13'($urandom);
      r.ord = 5'($urandom);
    end
    return r;
  endfunction

  task automatic send_request(req_row_t r);
    rsp_word_t w;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid = 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    req_ch.valid = 1;
    req_ch.mode = r.mode;
    req_ch.page_number = r.page;
    req_ch.count = r.cnt;
    req_ch.order = r.ord;
    do @(posedge clk); while (!req_ch.ready);
    w = allocate_or_free(r);
    if (r.typed) begin
      w.st = r.st;
      w.pg = r.pg;
    end
    pending_rsp.push_back(w);
    n_sent++;
    if (n_sent > 380) idle_on = 0;
    @(negedge clk);
  endtask

  initial begin
    req_row_t table_rows[$];
    req_ch.valid = 0;
    req_ch.mode = bpa_pkg::MODE_COUNT;
    req_ch.page_number = 0;
    req_ch.count = 0;
    req_ch.order = 0;
    foreach (free_num[i]) free_num[i] = 0;
    repeat (8) @(negedge clk);
    rst = 0;
    table_rows = '{
      row(bpa_pkg::MODE_COUNT, 0, 1, 0, 1, bpa_pkg::ST_OOM),
      row(bpa_pkg::MODE_BAD, 4095, 8191, 31, 1, bpa_pkg::ST_INVALID),
      row(bpa_pkg::MODE_COUNT, 0, 0, 0, 1, bpa_pkg::ST_INVALID),
      row(bpa_pkg::MODE_COUNT, 0, 1025, 0, 1, bpa_pkg::ST_INVALID),
      row(bpa_pkg::MODE_ORDER, 0, 0, 11, 1, bpa_pkg::ST_INVALID),
      row(bpa_pkg::MODE_ORDER, 0, 0, 31, 1, bpa_pkg::ST_INVALID),
      row(bpa_pkg::MODE_FREE, 0, 4096, 0, 1, bpa_pkg::ST_OK),
      row(bpa_pkg::MODE_FREE, 5, 0, 0, 1, bpa_pkg::ST_OK),
      row(bpa_pkg::MODE_FREE, 4095, 2, 0, 1, bpa_pkg::ST_INVALID),
      row(bpa_pkg::MODE_FREE, 100, 8191, 0, 1, bpa_pkg::ST_INVALID),
      row(bpa_pkg::MODE_FREE, 1, 4095, 0, 1, bpa_pkg::ST_OK),
      row(bpa_pkg::MODE_ORDER, 0, 0, 10),
      row(bpa_pkg::MODE_COUNT, 0, 1024, 0),
      row(bpa_pkg::MODE_COUNT, 0, 1, 0),
      row(bpa_pkg::MODE_COUNT, 0, 3, 0),
      row(bpa_pkg::MODE_ORDER, 0, 0, 0),
      row(bpa_pkg::MODE_FREE, 4095, 1, 0),
      row(bpa_pkg::MODE_FREE, 4095, 1, 0),
      row(bpa_pkg::MODE_COUNT, 0, 1000, 0),
      row(bpa_pkg::MODE_ORDER, 0, 0, 10),
      row(bpa_pkg::MODE_ORDER, 0, 0, 10),
      row(bpa_pkg::MODE_ORDER, 0, 0, 10),
      row(bpa_pkg::MODE_FREE, 2048, 2048, 0)
    };
    foreach (table_rows[i]) send_request(table_rows[i]);
    repeat (NRAND) send_request(random_request());
    req_ch.valid = 0;
    sending = 0;
    while (pending_rsp.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int hold;
    bit pressed;
    hold = 0;
    pressed = 0;
    rsp_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (!pressed && n_sent == 150) begin
        pressed = 1;
        hold = 300;
      end else if (hold == 0 && idle_on && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 19);
      end
      if (hold > 0) begin
        hold--;
        rsp_ch.ready = 0;
      end else begin
        rsp_ch.ready = 1;
      end
    end
  end

  always @(posedge clk) begin
    rsp_word_t w;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response status=%0d page=%0d", rsp_ch.status,
               rsp_ch.page_number_res);
        errors++;
      end else begin
        w = pending_rsp.pop_front();
        if (rsp_ch.status !== w.st) begin
          $error("status expected %0d actual %0d", w.st, rsp_ch.status);
          errors++;
        end
        if (rsp_ch.page_number_res !== w.pg) begin
          $error("page_number_res expected %0d actual %0d", w.pg,
                 rsp_ch.page_number_res);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= WDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end
endmodule

/* filelist.f */
rtl/bpa_pkg.sv
rtl/bpa_if.sv
rtl/bpa_ctrl.sv
rtl/bpa_dp.sv
rtl/buddy_page_allocator.sv
tb/testbench.sv
